// ===== hdl/fpid_pkg.sv =====
package fpid_pkg;

    localparam int ERR_UNIT  = 256;
    localparam int RATE_UNIT = 2560;
    localparam int ONE_Q16   = 65536;
    localparam int DELTA_LIMIT = 50331648;
    localparam int SCALE_W   = 25;
    localparam int MEMB_W    = 17;
    localparam int MAG_W     = 19;

    // reciprocal of five, exact floor for all operands below 2^22
    localparam logic [19:0] RECIP5 = 20'd838861;
    localparam int RECIP5_SHIFT = 22;

    typedef enum logic [2:0] {
        NB = 3'd0,
        NM = 3'd1,
        NS = 3'd2,
        ZO = 3'd3,
        PS = 3'd4,
        PM = 3'd5,
        PB = 3'd6
    } set_t;

    typedef enum logic [1:0] {
        KIND_P    = 2'd0,
        KIND_I    = 2'd1,
        KIND_D    = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_P_SCALE = 2'd0,
        REG_I_SCALE = 2'd1,
        REG_D_SCALE = 2'd2
    } cfg_reg_t;

    typedef logic [MEMB_W-1:0] memb_t;
    typedef memb_t [6:0] memb_vec_t;

    typedef struct packed {
        logic signed [15:0] err_value;
        logic signed [15:0] err_rate;
        logic [1:0]         kind;
    } in_item_t;

    typedef struct packed {
        logic signed [26:0] gain_delta;
        logic [16:0]        strength;
    } result_t;

    localparam set_t RULE_TAB [3][7][7] = '{
        '{
            '{PB, PB, PM, PM, PS, ZO, ZO},
            '{PB, PB, PM, PS, PS, ZO, NS},
            '{PM, PM, PM, PS, ZO, NS, NS},
            '{PM, PM, PS, ZO, NS, NM, NM},
            '{PS, PS, ZO, NS, NS, NM, NM},
            '{PS, ZO, NS, NM, NM, NM, NB},
            '{ZO, ZO, NM, NM, NM, NB, NB}
        },
        '{
            '{NB, NB, NM, NM, NS, ZO, ZO},
            '{NB, NB, NM, NS, NS, ZO, ZO},
            '{NB, NM, NS, NS, ZO, PS, PS},
            '{NM, NM, NS, ZO, PS, PM, PM},
            '{NM, NS, ZO, PS, PS, PM, PB},
            '{ZO, ZO, PS, PS, PM, PB, PB},
            '{ZO, ZO, PS, PM, PM, PB, PB}
        },
        '{
            '{PS, NS, NB, NB, NB, NM, PS},
            '{PS, NS, NB, NM, NM, NS, ZO},
            '{ZO, NS, NM, NM, NS, NS, ZO},
            '{ZO, NS, NS, NS, NS, NS, ZO},
            '{ZO, ZO, ZO, ZO, ZO, ZO, ZO},
            '{PB, NS, PS, PS, PS, PS, PB},
            '{PB, PM, PM, PM, PS, PS, PB}
        }
    };

    function automatic memb_t div5(input logic [18:0] n);
        logic [41:0] p;
        p = {23'd0, n} * {22'd0, RECIP5};
        return memb_t'(p >> RECIP5_SHIFT);
    endfunction

    // ramps over 10240 and 5120 counts: 65536/10240 = 32/5, 65536/5120 = 64/5
    function automatic memb_t ramp_long(input int d);
        return div5(19'(d * 32));
    endfunction

    function automatic memb_t ramp_short(input int d);
        return div5(19'(d * 64));
    endfunction

    function automatic memb_vec_t mf_err(input logic signed [15:0] x);
        int xi;
        int u;
        memb_vec_t m;
        xi = int'(x);
        u  = ERR_UNIT;
        m  = '0;
        if (xi <= -6*u)
            m[NB] = memb_t'(ONE_Q16);
        else if (xi <= -2*u)
            m[NB] = memb_t'((-2*u - xi) * 64);
        if (xi > -6*u && xi <= -4*u)
            m[NM] = memb_t'((xi + 6*u) * 128);
        else if (xi > -4*u && xi <= 0)
            m[NM] = memb_t'((0 - xi) * 64);
        if (xi > -6*u && xi <= -2*u)
            m[NS] = memb_t'((xi + 6*u) * 64);
        else if (xi > -2*u && xi <= 2*u)
            m[NS] = memb_t'((2*u - xi) * 64);
        if (xi > -4*u && xi <= 0)
            m[ZO] = memb_t'((xi + 4*u) * 64);
        else if (xi > 0 && xi <= 4*u)
            m[ZO] = memb_t'((4*u - xi) * 64);
        if (xi > -2*u && xi <= 2*u)
            m[PS] = memb_t'((xi + 2*u) * 64);
        else if (xi > 2*u && xi <= 6*u)
            m[PS] = memb_t'((6*u - xi) * 64);
        if (xi > 0 && xi <= 4*u)
            m[PM] = memb_t'(xi * 64);
        else if (xi > 4*u && xi <= 6*u)
            m[PM] = memb_t'((6*u - xi) * 128);
        if (xi >= 6*u)
            m[PB] = memb_t'(ONE_Q16);
        else if (xi > 2*u)
            m[PB] = memb_t'((xi - 2*u) * 64);
        return m;
    endfunction

    function automatic memb_vec_t mf_rate(input logic signed [15:0] x);
        int xi;
        int u;
        memb_vec_t m;
        xi = int'(x);
        u  = RATE_UNIT;
        m  = '0;
        if (xi <= -6*u)
            m[NB] = memb_t'(ONE_Q16);
        else if (xi <= -2*u)
            m[NB] = ramp_long(-2*u - xi);
        if (xi > -6*u && xi <= -4*u)
            m[NM] = ramp_short(xi + 6*u);
        else if (xi > -4*u && xi <= 0)
            m[NM] = ramp_long(0 - xi);
        if (xi > -6*u && xi <= -2*u)
            m[NS] = ramp_long(xi + 6*u);
        else if (xi > -2*u && xi <= 2*u)
            m[NS] = ramp_long(2*u - xi);
        if (xi > -4*u && xi <= 0)
            m[ZO] = ramp_long(xi + 4*u);
        else if (xi > 0 && xi <= 4*u)
            m[ZO] = ramp_long(4*u - xi);
        if (xi > -2*u && xi <= 2*u)
            m[PS] = ramp_long(xi + 2*u);
        else if (xi > 2*u && xi <= 6*u)
            m[PS] = ramp_long(6*u - xi);
        if (xi > 0 && xi <= 4*u)
            m[PM] = ramp_long(xi);
        else if (xi > 4*u && xi <= 6*u)
            m[PM] = ramp_short(6*u - xi);
        if (xi >= 6*u)
            m[PB] = memb_t'(ONE_Q16);
        else if (xi > 2*u)
            m[PB] = ramp_long(xi - 2*u);
        return m;
    endfunction

endpackage

// ===== hdl/fuzzy_pid_gain_adjust.sv =====
// throughput: one transaction per cycle, busy stays low; seven pipeline registers in a row
// (input, fuzzify, row maximum, winner, rule lookup, scale multiply, round and saturate)
// reset: asynchronous, active low; clears the pipeline valid bits and done, and loads
// the scale registers with 1.0, 0.0005 and 0.1; results cannot be stalled by the receiver
module fuzzy_pid_gain_adjust (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  fpid_pkg::in_item_t     item,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [24:0]            cfg_wdata,
    output logic                   done,
    output fpid_pkg::result_t      result
);

    logic [fpid_pkg::SCALE_W-1:0] p_scale_reg;
    logic [fpid_pkg::SCALE_W-1:0] i_scale_reg;
    logic [fpid_pkg::SCALE_W-1:0] d_scale_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, done_reg;

    fpid_pkg::in_item_t    item0_reg;
    fpid_pkg::memb_vec_t   me1_reg, mr1_reg;
    logic [1:0]            kind1_reg, kind2_reg, kind3_reg;
    fpid_pkg::memb_t       row_best2_reg [7];
    logic [2:0]            row_col2_reg [7];
    fpid_pkg::memb_t       best3_reg, best4_reg, best5_reg;
    logic [2:0]            bi3_reg, bj3_reg;
    logic [fpid_pkg::MAG_W-1:0]   mag4_reg;
    logic                  neg4_reg, neg5_reg;
    logic [fpid_pkg::SCALE_W-1:0] scale4_reg;
    logic [43:0]           prod5_reg;
    fpid_pkg::result_t     result_reg;

    fpid_pkg::memb_t       row_best_next [7];
    logic [2:0]            row_col_next [7];
    fpid_pkg::memb_t       best_next;
    logic [2:0]            bi_next, bj_next;
    logic [fpid_pkg::MAG_W-1:0]   mag_next;
    logic                  neg_next;
    logic [fpid_pkg::SCALE_W-1:0] scale_next;
    fpid_pkg::set_t        set_sel;
    fpid_pkg::result_t     result_next;
    logic [28:0]           rounded;
    logic [26:0]           sat_mag;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_scale_reg <= 25'd16777216;
            i_scale_reg <= 25'd8389;
            d_scale_reg <= 25'd1677722;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fpid_pkg::REG_P_SCALE: p_scale_reg <= cfg_wdata;
                fpid_pkg::REG_I_SCALE: i_scale_reg <= cfg_wdata;
                fpid_pkg::REG_D_SCALE: d_scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // row-wise first maximum of min(error set, rate set)
    always_comb
    begin
        fpid_pkg::memb_t cand;
        for (int i = 0; i < 7; i++)
        begin
            row_best_next[i] = (me1_reg[i] < mr1_reg[0]) ? me1_reg[i] : mr1_reg[0];
            row_col_next[i]  = 3'd0;
            for (int j = 1; j < 7; j++)
            begin
                cand = (me1_reg[i] < mr1_reg[j]) ? me1_reg[i] : mr1_reg[j];
                if (cand > row_best_next[i])
                begin
                    row_best_next[i] = cand;
                    row_col_next[i]  = 3'(j);
                end
            end
        end
    end

    // strict compare keeps the earliest row on ties
    always_comb
    begin
        best_next = row_best2_reg[0];
        bi_next   = 3'd0;
        bj_next   = row_col2_reg[0];
        for (int i = 1; i < 7; i++)
        begin
            if (row_best2_reg[i] > best_next)
            begin
                best_next = row_best2_reg[i];
                bi_next   = 3'(i);
                bj_next   = row_col2_reg[i];
            end
        end
    end

    // rule lookup and normalized defuzzified magnitude in units of 2^-17
    always_comb
    begin
        unique case (kind3_reg)
            fpid_pkg::KIND_P:
            begin
                set_sel    = fpid_pkg::RULE_TAB[0][bi3_reg][bj3_reg];
                scale_next = p_scale_reg;
            end
            fpid_pkg::KIND_I:
            begin
                set_sel    = fpid_pkg::RULE_TAB[1][bi3_reg][bj3_reg];
                scale_next = i_scale_reg;
            end
            fpid_pkg::KIND_D:
            begin
                set_sel    = fpid_pkg::RULE_TAB[2][bi3_reg][bj3_reg];
                scale_next = d_scale_reg;
            end
            default:
            begin
                // unused kind code gives a zero delta
                set_sel    = fpid_pkg::ZO;
                scale_next = '0;
            end
        endcase

        unique case (set_sel)
            fpid_pkg::NB:
            begin
                neg_next = 1'b1;
                mag_next = 19'd131072 + {best3_reg, 2'b00};
            end
            fpid_pkg::NM:
            begin
                neg_next = 1'b1;
                mag_next = 19'd196608 + 19'(best3_reg);
            end
            fpid_pkg::NS:
            begin
                neg_next = 1'b1;
                mag_next = 19'd131072;
            end
            fpid_pkg::PS:
            begin
                neg_next = 1'b0;
                mag_next = 19'd131072;
            end
            fpid_pkg::PM:
            begin
                neg_next = 1'b0;
                mag_next = 19'd196608 + 19'(best3_reg);
            end
            fpid_pkg::PB:
            begin
                neg_next = 1'b0;
                mag_next = 19'd131072 + {best3_reg, 2'b00};
            end
            default:
            begin
                neg_next = 1'b0;
                mag_next = '0;
            end
        endcase
    end

    // round half away from zero, then saturate to +-3.0
    always_comb
    begin
        rounded = 29'(({2'b00, prod5_reg} + 46'd65536) >> 17);
        if (rounded > 29'(fpid_pkg::DELTA_LIMIT))
            sat_mag = 27'(fpid_pkg::DELTA_LIMIT);
        else
            sat_mag = rounded[26:0];
        result_next.gain_delta = neg5_reg ? -$signed(sat_mag) : $signed(sat_mag);
        result_next.strength   = best5_reg;
    end

    always_ff @(posedge clk)
    begin
        item0_reg  <= item;
        me1_reg    <= fpid_pkg::mf_err(item0_reg.err_value);
        mr1_reg    <= fpid_pkg::mf_rate(item0_reg.err_rate);
        kind1_reg  <= item0_reg.kind;
        row_best2_reg <= row_best_next;
        row_col2_reg  <= row_col_next;
        kind2_reg  <= kind1_reg;
        best3_reg  <= best_next;
        bi3_reg    <= bi_next;
        bj3_reg    <= bj_next;
        kind3_reg  <= kind2_reg;
        mag4_reg   <= mag_next;
        neg4_reg   <= neg_next;
        scale4_reg <= scale_next;
        best4_reg  <= best3_reg;
        prod5_reg  <= {25'd0, mag4_reg} * {19'd0, scale4_reg};
        neg5_reg   <= neg4_reg;
        best5_reg  <= best4_reg;
        result_reg <= result_next;
    end

endmodule

// ===== hdl/fpid_checker.sv =====
module fpid_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input fpid_pkg::in_item_t  item,
    input logic                done,
    input fpid_pkg::result_t   result
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the pipeline always accepts");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
        else $error("result strobe without a transaction seven edges earlier");

    a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.strength <= 17'd65536)
        else $error("strength above 1.0");

    a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.gain_delta <= 27'sd50331648 && result.gain_delta >= -27'sd50331648))
        else $error("gain delta outside saturation limits");

    a_unused_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && item.kind == fpid_pkg::KIND_NONE, 7))
            |-> result.gain_delta == 27'sd0)
        else $error("unused kind code produced a nonzero delta");

endmodule

bind fuzzy_pid_gain_adjust fpid_checker u_fpid_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

// ===== sim/tb_fuzzy_pid_gain_adjust.sv =====
`timescale 1ns / 1ps

module tb_fuzzy_pid_gain_adjust;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PIPE_DEPTH = 7;
    localparam int ITEMS_PER_SETTING = 200;
    localparam logic [24:0] SCALE_ONE = 25'd16777216;
    localparam logic [24:0] SCALE_MAX = 25'h1FFFFFF;

    localparam fpid_pkg::set_t NB = fpid_pkg::NB;
    localparam fpid_pkg::set_t NM = fpid_pkg::NM;
    localparam fpid_pkg::set_t NS = fpid_pkg::NS;
    localparam fpid_pkg::set_t ZO = fpid_pkg::ZO;
    localparam fpid_pkg::set_t PS = fpid_pkg::PS;
    localparam fpid_pkg::set_t PM = fpid_pkg::PM;
    localparam fpid_pkg::set_t PB = fpid_pkg::PB;

    // output set per (error set, rate set) cell, one table per gain kind
    localparam fpid_pkg::set_t RULE_MAP [3][7][7] = '{
        '{
            '{PB, PB, PM, PM, PS, ZO, ZO},
            '{PB, PB, PM, PS, PS, ZO, NS},
            '{PM, PM, PM, PS, ZO, NS, NS},
            '{PM, PM, PS, ZO, NS, NM, NM},
            '{PS, PS, ZO, NS, NS, NM, NM},
            '{PS, ZO, NS, NM, NM, NM, NB},
            '{ZO, ZO, NM, NM, NM, NB, NB}
        },
        '{
            '{NB, NB, NM, NM, NS, ZO, ZO},
            '{NB, NB, NM, NS, NS, ZO, ZO},
            '{NB, NM, NS, NS, ZO, PS, PS},
            '{NM, NM, NS, ZO, PS, PM, PM},
            '{NM, NS, ZO, PS, PS, PM, PB},
            '{ZO, ZO, PS, PS, PM, PB, PB},
            '{ZO, ZO, PS, PM, PM, PB, PB}
        },
        '{
            '{PS, NS, NB, NB, NB, NM, PS},
            '{PS, NS, NB, NM, NM, NS, ZO},
            '{ZO, NS, NM, NM, NS, NS, ZO},
            '{ZO, NS, NS, NS, NS, NS, ZO},
            '{ZO, ZO, ZO, ZO, ZO, ZO, ZO},
            '{PB, NS, PS, PS, PS, PS, PB},
            '{PB, PM, PM, PM, PS, PS, PB}
        }
    };

    class gain_scoreboard;
        logic [24:0] p_sc;
        logic [24:0] i_sc;
        logic [24:0] d_sc;
        fpid_pkg::result_t pending_deltas[$];
        int compared;
        int errors;

        function new();
            p_sc = SCALE_ONE;
            i_sc = 25'd8389;
            d_sc = 25'd1677722;
            compared = 0;
            errors = 0;
        endfunction

        function void set_scale(fpid_pkg::cfg_reg_t idx, logic [24:0] v);
            case (idx)
                fpid_pkg::REG_P_SCALE: p_sc = v;
                fpid_pkg::REG_I_SCALE: i_sc = v;
                fpid_pkg::REG_D_SCALE: d_sc = v;
                default: ;
            endcase
        endfunction

        function int ramp(int num, int den);
            return int'((longint'(num) * fpid_pkg::ONE_Q16) / den);
        endfunction

        function int peak(int x, int a, int b, int c);
            if (x <= a || x > c)
                return 0;
            if (x <= b)
                return ramp(x - a, b - a);
            return ramp(c - x, c - b);
        endfunction

        function fpid_pkg::memb_vec_t fuzzify(int x, int u);
            fpid_pkg::memb_vec_t m;
            if (x <= -6*u)
                m[NB] = fpid_pkg::memb_t'(fpid_pkg::ONE_Q16);
            else if (x <= -2*u)
                m[NB] = fpid_pkg::memb_t'(ramp(-2*u - x, 4*u));
            else
                m[NB] = '0;
            m[NM] = fpid_pkg::memb_t'(peak(x, -6*u, -4*u, 0));
            m[NS] = fpid_pkg::memb_t'(peak(x, -6*u, -2*u, 2*u));
            m[ZO] = fpid_pkg::memb_t'(peak(x, -4*u, 0, 4*u));
            m[PS] = fpid_pkg::memb_t'(peak(x, -2*u, 2*u, 6*u));
            m[PM] = fpid_pkg::memb_t'(peak(x, 0, 4*u, 6*u));
            if (x <= 2*u)
                m[PB] = '0;
            else if (x < 6*u)
                m[PB] = fpid_pkg::memb_t'(ramp(x - 2*u, 4*u));
            else
                m[PB] = fpid_pkg::memb_t'(fpid_pkg::ONE_Q16);
            return m;
        endfunction

        // work out the gain change of one accepted transaction and queue it
        function void note(fpid_pkg::in_item_t it);
            fpid_pkg::memb_vec_t me;
            fpid_pkg::memb_vec_t mr;
            int fire;
            int best;
            int bi;
            int bj;
            fpid_pkg::set_t pick;
            longint v;
            longint mag;
            logic [24:0] sc;
            bit neg;
            fpid_pkg::result_t r;
            me = fuzzify(int'($signed(it.err_value)), fpid_pkg::ERR_UNIT);
            mr = fuzzify(int'($signed(it.err_rate)), fpid_pkg::RATE_UNIT);
            best = 0;
            bi = 0;
            bj = 0;
            for (int i = 0; i < 7; i++)
            begin
                for (int j = 0; j < 7; j++)
                begin
                    fire = (me[i] < mr[j]) ? int'(me[i]) : int'(mr[j]);
                    if (i == 0 && j == 0)
                        best = fire;
                    else if (fire > best)
                    begin
                        best = fire;
                        bi = i;
                        bj = j;
                    end
                end
            end
            r.strength = 17'(best);
            r.gain_delta = '0;
            if (it.kind != fpid_pkg::KIND_NONE)
            begin
                pick = RULE_MAP[it.kind][bi][bj];
                case (pick)
                    NB: v = -131072 - 4 * longint'(best);
                    NM: v = -196608 - longint'(best);
                    NS: v = -131072;
                    ZO: v = 0;
                    PS: v = 131072;
                    PM: v = 196608 + longint'(best);
                    default: v = 131072 + 4 * longint'(best);
                endcase
                case (it.kind)
                    fpid_pkg::KIND_P: sc = p_sc;
                    fpid_pkg::KIND_I: sc = i_sc;
                    default: sc = d_sc;
                endcase
                neg = v < 0;
                mag = ((neg ? -v : v) * longint'(sc) + 65536) >>> 17;
                if (mag > fpid_pkg::DELTA_LIMIT)
                    mag = fpid_pkg::DELTA_LIMIT;
                r.gain_delta = 27'(neg ? -mag : mag);
            end
            pending_deltas.push_back(r);
        endfunction

        function void check(fpid_pkg::result_t got);
            fpid_pkg::result_t want;
            if (pending_deltas.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, gain_delta %0d strength %0d", $time,
                         $signed(got.gain_delta), got.strength);
                return;
            end
            want = pending_deltas.pop_front();
            compared++;
            if (got.gain_delta !== want.gain_delta)
            begin
                errors++;
                $display("%0t: gain_delta mismatch, expected %0d, actual %0d", $time,
                         $signed(want.gain_delta), $signed(got.gain_delta));
            end
            if (got.strength !== want.strength)
            begin
                errors++;
                $display("%0t: strength mismatch, expected %0d, actual %0d", $time,
                         want.strength, got.strength);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    fpid_pkg::in_item_t cmd_item = '0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [24:0] cfg_wdata = '0;
    logic done;
    fpid_pkg::result_t res_out;

    gain_scoreboard sb;
    bit steady;
    int sent;
    int settings;
    int cycle_count;

    fuzzy_pid_gain_adjust u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (cmd_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (res_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(res_out);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly inside the universe, some on breakpoints, some anywhere in 16 bits
    function automatic int rand_input(int u);
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return int'($signed(16'($urandom)));
        if (roll == 1)
            return (2 * int'($urandom_range(6)) - 6) * u + int'($urandom_range(4)) - 2;
        return int'($urandom_range(14 * u)) - 7 * u;
    endfunction

    task automatic send(input int e, input int r, input logic [1:0] k);
        fpid_pkg::in_item_t it;
        int gap;
        it.err_value = 16'(e);
        it.err_rate = 16'(r);
        it.kind = k;
        start <= 1'b1;
        cmd_item <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note(it);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off new transactions until the pipeline has emptied
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_deltas.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input fpid_pkg::cfg_reg_t idx, input logic [24:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_scale(idx, v);
    endtask

    task automatic write_scales(input logic [24:0] p, input logic [24:0] i,
                                input logic [24:0] d);
        write_reg(fpid_pkg::REG_P_SCALE, p);
        write_reg(fpid_pkg::REG_I_SCALE, i);
        write_reg(fpid_pkg::REG_D_SCALE, d);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic random_phase();
        logic [1:0] k;
        for (int n = 0; n < ITEMS_PER_SETTING; n++)
        begin
            if (n % 48 == 0)
                steady = ($urandom_range(3) == 0);
            k = ($urandom_range(7) == 0) ? fpid_pkg::KIND_NONE : 2'($urandom_range(2));
            send(rand_input(fpid_pkg::ERR_UNIT), rand_input(fpid_pkg::RATE_UNIT), k);
        end
        steady = 1'b0;
        drain();
    endtask

    initial
    begin
        sb = new();
        steady = 1'b0;
        sent = 0;
        settings = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners of the universe, breakpoints, ties and every kind at reset scales
        send(-32768, -32768, fpid_pkg::KIND_P);
        send(32767, 32767, fpid_pkg::KIND_I);
        send(-32768, 32767, fpid_pkg::KIND_D);
        send(32767, -32768, fpid_pkg::KIND_NONE);
        send(0, 0, fpid_pkg::KIND_P);
        send(0, 0, fpid_pkg::KIND_I);
        send(0, 0, fpid_pkg::KIND_D);
        send(0, 0, fpid_pkg::KIND_NONE);
        send(-1536, -15360, fpid_pkg::KIND_P);
        send(1536, 15360, fpid_pkg::KIND_I);
        send(-1024, 10240, fpid_pkg::KIND_D);
        send(1024, -10240, fpid_pkg::KIND_P);
        send(-512, 5120, fpid_pkg::KIND_I);
        send(512, -5120, fpid_pkg::KIND_D);
        send(-1, 1, fpid_pkg::KIND_P);
        send(1, -1, fpid_pkg::KIND_I);
        send(-256, 2560, fpid_pkg::KIND_D);
        send(384, -3840, fpid_pkg::KIND_P);
        send(-1535, 15359, fpid_pkg::KIND_I);
        send(1537, -15361, fpid_pkg::KIND_D);
        send(-16, -16, fpid_pkg::KIND_NONE);
        drain();

        // saturation with full-range scales, zero scales, then random and reset values
        write_scales(SCALE_MAX, '0, SCALE_ONE);
        random_phase();
        write_scales('0, SCALE_MAX, 25'd1);
        random_phase();
        write_scales(SCALE_ONE, SCALE_ONE, SCALE_MAX);
        random_phase();
        write_scales(25'($urandom), 25'($urandom), 25'($urandom));
        random_phase();
        write_scales(25'($urandom_range(16777216)), 25'($urandom_range(16777216)),
                     25'($urandom_range(16777216)));
        random_phase();
        write_scales(SCALE_ONE, 25'd8389, 25'd1677722);
        random_phase();

        repeat (PIPE_DEPTH + 4) @(posedge clk);
        $display("%0d transactions over %0d scale settings, including saturating scales,",
                 sent, settings);
        $display("unused kind and out-of-universe inputs; %0d results compared, %0d errors",
                 sb.compared, sb.errors + sb.pending_deltas.size());
        if (sb.errors == 0 && sb.pending_deltas.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fpid_pkg.sv
hdl/fuzzy_pid_gain_adjust.sv
hdl/fpid_checker.sv
sim/tb_fuzzy_pid_gain_adjust.sv
